// ===== rtl/tcs_pkg.sv =====
// Shared types, command and result codes, and default sizes of the task scheduler.
package tcs_pkg;

	// Default configuration handed to the top level.
	localparam int DEF_MAX_TASKS = 8;
	localparam int DEF_TICK_LEN  = 10;

	// Widths fixed by the item fields.
	localparam int HANDLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int SLOT_W   = 3;
	localparam int RUN_W    = 8;

	// A dispatch reports at most this many tasks.
	localparam int RESULT_CAP = 8;

	// Depths of the queues between the front, the back and the result port.
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 4;

	// Command codes of an input item.
	localparam logic [1:0] CMD_ADD      = 2'd0;
	localparam logic [1:0] CMD_REMOVE   = 2'd1;
	localparam logic [1:0] CMD_TICK     = 2'd2;
	localparam logic [1:0] CMD_DISPATCH = 2'd3;

	// Kind codes of a result item.
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_RUN    = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// Command as it travels from the front to the back. For an add, delay_ms
	// and period_ms hold the values already converted to ticks.
	typedef struct packed {
		logic [1:0]          cmd;
		logic [HANDLE_W-1:0] task_handle;
		logic [TIME_W-1:0]   delay_ms;
		logic [TIME_W-1:0]   period_ms;
		logic [SLOT_W-1:0]   slot;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic                ok;
		logic [SLOT_W-1:0]   slot_out;
		logic [HANDLE_W-1:0] handle_out;
		logic                last;
	} result_t;

endpackage

// ===== rtl/tcs_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
module tcs_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CNW-1:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ===== rtl/tcs_front.sv =====
// Front end: takes input items and converts add times to ticks by reciprocal multiplication.
module tcs_front #(
	parameter int TICK_LEN = tcs_pkg::DEF_TICK_LEN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tcs_pkg::cmd_item_t in_item,
	output logic               cmd_push,
	input  logic               cmd_full,
	output tcs_pkg::cmd_item_t cmd_item
);
	import tcs_pkg::*;

	localparam int SH_L  = $clog2(TICK_LEN);
	localparam int SHIFT = TIME_W + SH_L;
	localparam int MW    = TIME_W + 1;
	localparam int PW    = TIME_W + MW;
	// Reciprocal of the tick length scaled by 2^SHIFT and rounded up; the bits of the
	// product above SHIFT are the exact quotient for every 32-bit dividend.
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SHIFT) / 64'(TICK_LEN)) + 64'd1);

	cmd_item_t      ent_q;
	logic           ent_v_q;
	logic           conv_q;
	logic [PW-1:0]  prod_d;
	logic [PW-1:0]  prod_p;
	logic           accept;

	assign full     = ent_v_q;
	assign accept   = push && !ent_v_q;
	assign cmd_push = ent_v_q && !conv_q;
	assign cmd_item = ent_q;

	assign prod_d = PW'(ent_q.delay_ms) * PW'(RECIP);
	assign prod_p = PW'(ent_q.period_ms) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_q <= 1'b0;
			conv_q  <= 1'b0;
		end else if (accept) begin
			ent_v_q <= 1'b1;
			conv_q  <= (in_item.cmd == CMD_ADD);
		end else if (conv_q) begin
			conv_q <= 1'b0;
		end else if (cmd_push && !cmd_full) begin
			ent_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q <= in_item;
		end else if (conv_q) begin
			ent_q.delay_ms  <= TIME_W'(prod_d >> SHIFT);
			ent_q.period_ms <= TIME_W'(prod_p >> SHIFT);
		end
	end

endmodule

// ===== rtl/tcs_back.sv =====
// Back end: holds the task table and carries out add, remove, tick and dispatch.
module tcs_back #(
	parameter int MAX_TASKS = tcs_pkg::DEF_MAX_TASKS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	input  tcs_pkg::cmd_item_t cmd_item,
	input  logic               res_full,
	output logic               res_push,
	output tcs_pkg::result_t   res_item
);
	import tcs_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;
	localparam int CW = $clog2(RESULT_CAP + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_DSP  = 2'd2;
	localparam logic [1:0] ST_DEND = 2'd3;

	logic [1:0]           state_q;
	logic [IW-1:0]        idx_q;
	logic [CW-1:0]        cnt_q;
	logic                 pend_v_q;
	logic [SLOT_W-1:0]    pend_slot_q;
	logic [HANDLE_W-1:0]  pend_handle_q;

	logic [MAX_TASKS-1:0] occ_q;
	logic [HANDLE_W-1:0]  hnd_q [MAX_TASKS];
	logic [TIME_W-1:0]    dly_q [MAX_TASKS];
	logic [TIME_W-1:0]    per_q [MAX_TASKS];
	logic [RUN_W-1:0]     rc_q  [MAX_TASKS];

	logic                 free_v;
	logic [IW-1:0]        free_idx;
	logic [SW-1:0]        free_w;
	logic [SW-1:0]        sl_w;
	logic [IW-1:0]        rm_idx;
	logic                 rm_ok;
	logic [SW-1:0]        idx_w;
	logic                 idle_cmd;
	logic                 add_go;
	logic                 rm_go;
	logic                 due;
	logic                 dsp_stall;
	logic                 dsp_take;
	logic                 walk_end;

	// Lowest free slot.
	always_comb begin
		free_v   = 1'b0;
		free_idx = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_v   = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign free_w    = SW'(free_idx);
	assign sl_w      = SW'(cmd_item.slot);
	assign rm_idx    = sl_w[IW-1:0];
	assign rm_ok     = (32'(cmd_item.slot) < 32'(MAX_TASKS)) && occ_q[rm_idx];
	assign idx_w     = SW'(idx_q);
	assign walk_end  = (idx_q == IW'(MAX_TASKS - 1));

	assign idle_cmd  = (state_q == ST_IDLE) && !cmd_empty;
	assign add_go    = idle_cmd && (cmd_item.cmd == CMD_ADD) && !res_full;
	assign rm_go     = idle_cmd && (cmd_item.cmd == CMD_REMOVE) && !res_full;
	assign due       = (rc_q[idx_q] != '0) && (cnt_q < CW'(RESULT_CAP));
	assign dsp_stall = due && pend_v_q && res_full;
	assign dsp_take  = (state_q == ST_DSP) && due && !dsp_stall;

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_item = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd_item.cmd)
						CMD_ADD: begin
							if (!res_full) begin
								cmd_pop           = 1'b1;
								res_push          = 1'b1;
								res_item.kind     = KIND_ADD;
								res_item.ok       = free_v;
								res_item.slot_out = free_v ? free_w[SLOT_W-1:0] : '0;
								res_item.last     = 1'b1;
							end
						end
						CMD_REMOVE: begin
							if (!res_full) begin
								cmd_pop           = 1'b1;
								res_push          = 1'b1;
								res_item.kind     = KIND_REMOVE;
								res_item.ok       = rm_ok;
								res_item.slot_out = cmd_item.slot;
								res_item.last     = 1'b1;
							end
						end
						CMD_TICK: begin
							cmd_pop = 1'b1;
						end
						CMD_DISPATCH: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ST_TICK: begin
			end
			ST_DSP: begin
				// The held result goes out once a later due slot shows it is not last.
				if (due && pend_v_q && !res_full) begin
					res_push            = 1'b1;
					res_item.kind       = KIND_RUN;
					res_item.slot_out   = pend_slot_q;
					res_item.handle_out = pend_handle_q;
				end
			end
			ST_DEND: begin
				if (!res_full) begin
					res_push = 1'b1;
					res_item.last = 1'b1;
					if (pend_v_q) begin
						res_item.kind       = KIND_RUN;
						res_item.slot_out   = pend_slot_q;
						res_item.handle_out = pend_handle_q;
					end else begin
						res_item.kind = KIND_NONE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (idle_cmd && (cmd_item.cmd == CMD_TICK)) begin
						state_q <= ST_TICK;
						idx_q   <= '0;
					end else if (idle_cmd && (cmd_item.cmd == CMD_DISPATCH)) begin
						state_q  <= ST_DSP;
						idx_q    <= '0;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
					end
				end
				ST_TICK: begin
					if (walk_end) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DSP: begin
					if (!dsp_stall) begin
						if (due) begin
							pend_v_q <= 1'b1;
							cnt_q    <= cnt_q + CW'(1);
						end
						if (walk_end) begin
							state_q <= ST_DEND;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_DEND: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dsp_take) begin
			pend_slot_q   <= idx_w[SLOT_W-1:0];
			pend_handle_q <= hnd_q[idx_q];
		end
	end

	// Task table. The command paths are exclusive by state and by command code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				hnd_q[i] <= '0;
				dly_q[i] <= '0;
				per_q[i] <= '0;
				rc_q[i]  <= '0;
			end
		end else if (add_go && free_v) begin
			occ_q[free_idx] <= (cmd_item.task_handle != '0);
			hnd_q[free_idx] <= cmd_item.task_handle;
			dly_q[free_idx] <= cmd_item.delay_ms;
			per_q[free_idx] <= cmd_item.period_ms;
			rc_q[free_idx]  <= '0;
		end else if (rm_go && rm_ok) begin
			occ_q[rm_idx] <= 1'b0;
			hnd_q[rm_idx] <= '0;
			dly_q[rm_idx] <= '0;
			per_q[rm_idx] <= '0;
			rc_q[rm_idx]  <= '0;
		end else if ((state_q == ST_TICK) && occ_q[idx_q]) begin
			if (dly_q[idx_q] == '0) begin
				if (rc_q[idx_q] != '1) begin
					rc_q[idx_q] <= rc_q[idx_q] + RUN_W'(1);
				end
				if (per_q[idx_q] != '0) begin
					dly_q[idx_q] <= per_q[idx_q];
				end
			end else begin
				dly_q[idx_q] <= dly_q[idx_q] - TIME_W'(1);
			end
		end else if (dsp_take) begin
			if (per_q[idx_q] == '0) begin
				// A one-shot task leaves the table once it has been reported.
				occ_q[idx_q] <= 1'b0;
				hnd_q[idx_q] <= '0;
				dly_q[idx_q] <= '0;
				rc_q[idx_q]  <= '0;
			end else begin
				rc_q[idx_q] <= rc_q[idx_q] - RUN_W'(1);
			end
		end
	end

endmodule

// ===== rtl/cooperative_task_scheduler.sv =====
// Top level of the time-triggered cooperative task scheduler.
// An add passes through the tick conversion in the front end before it reaches the command
// queue; tick and dispatch walk every slot of the task table in the back end.
// Reset is asynchronous and active low; it empties the task table and all queues at once.
module cooperative_task_scheduler #(
	parameter int MAX_TASKS = tcs_pkg::DEF_MAX_TASKS,
	parameter int TICK_LEN  = tcs_pkg::DEF_TICK_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [15:0] task_handle,
	input  logic [31:0] delay_ms,
	input  logic [31:0] period_ms,
	input  logic [2:0]  slot,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic        ok,
	output logic [2:0]  slot_out,
	output logic [15:0] handle_out,
	output logic        last
);
	import tcs_pkg::*;

	// The front end holds one item at a time. For an add it converts the delay
	// and the period to ticks by multiplying with the rounded-up reciprocal of
	// the tick length, while the back end is free to keep working on earlier
	// commands from the command queue.
	cmd_item_t in_item;
	cmd_item_t cmd_in;
	cmd_item_t cmd_out;
	logic      cmd_push;
	logic      cmd_full;
	logic      cmd_pop;
	logic      cmd_empty;

	// The back end walks the task table for tick and dispatch, one slot per cycle unless
	// a full result queue stalls a dispatch, and feeds the ports through the result queue.
	result_t   res_in;
	result_t   res_out;
	logic      res_push;
	logic      res_full;

	assign in_item.cmd         = cmd;
	assign in_item.task_handle = task_handle;
	assign in_item.delay_ms    = delay_ms;
	assign in_item.period_ms   = period_ms;
	assign in_item.slot        = slot;

	tcs_front #(
		.TICK_LEN (TICK_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full),
		.cmd_item (cmd_in)
	);

	tcs_fifo #(
		.T     (cmd_item_t),
		.DEPTH (CMDQ_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	tcs_back #(
		.MAX_TASKS (MAX_TASKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd_item  (cmd_out),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_in)
	);

	// The result queue decouples the back end from a slow consumer; the oldest
	// result sits on the output ports while the queue is not empty.
	tcs_fifo #(
		.T     (result_t),
		.DEPTH (RESQ_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign kind       = res_out.kind;
	assign ok         = res_out.ok;
	assign slot_out   = res_out.slot_out;
	assign handle_out = res_out.handle_out;
	assign last       = res_out.last;

`ifndef SYNTHESIS
	a_cmd_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("back end took a command from an empty command queue");
	a_res_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("back end wrote a result into a full result queue");
	a_only_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (kind == KIND_RUN))
		else $error("a result other than a task to run was not marked last");
	a_none_is_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == KIND_NONE)) |-> (last && !ok && (handle_out == 16'd0)))
		else $error("malformed none-due result");
`endif

endmodule
